// ===== design/pdc_pkg.sv =====
// Shared types and constants of the PID duty controller.
package pdc_pkg;

  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 8;
  localparam int ERR_W    = 19;
  localparam int INTEG_W  = 32;
  localparam int DUTY_W   = 7;
  localparam int DUTY_MAX = 100;
  localparam int ERR_MAX  = 262143;
  localparam int ERR_MIN  = -262144;

  // The shared multiplier takes a signed 33-bit operand and a gain or
  // scale zero-extended to a signed 17-bit operand.
  localparam int MUL_A_W = INTEG_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  // Bit position of the integer part of the control sum.
  localparam int DUTY_SHIFT = 20;

  localparam int STEP_W = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [2:0] REG_SETPOINT_SCALE = 3'd3;
  localparam logic [2:0] REG_SENSOR_SCALE   = 3'd4;

  typedef enum logic [2:0] {
    A_SETPOINT = 3'd0,
    A_SENSOR   = 3'd1,
    A_ERROR    = 3'd2,
    A_INTEGRAL = 3'd3,
    A_DERIV    = 3'd4
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SETPOINT_SCALE = 3'd0,
    B_SENSOR_SCALE   = 3'd1,
    B_PROP_GAIN      = 3'd2,
    B_INTEG_GAIN     = 3'd3,
    B_DERIV_GAIN     = 3'd4
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_WAIT_IN  = 2'd1,
    COND_WAIT_OUT = 2'd2
  } cond_t;

  // One microcode word.
  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    logic    load_set;
    logic    load_err;
    logic    update_state;
    acc_op_t acc_op;
    cond_t   cond;
    logic    accept_in;
    logic    finish;
    logic    last;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SCALE_W-1:0] setpoint_scale;
    logic [SCALE_W-1:0] sensor_scale;
  } cfg_t;

endpackage

// ===== design/pdc_sequencer.sv =====
// Step counter and microcode table that drive the PID datapath.
module pdc_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  pdc_pkg::status_t status,
  output pdc_pkg::ctrl_t   ctrl
);
  import pdc_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              hold;

  always_comb begin
    ctrl = '0;
    ctrl.a_sel  = A_SETPOINT;
    ctrl.b_sel  = B_SETPOINT_SCALE;
    ctrl.acc_op = ACC_HOLD;
    ctrl.cond   = COND_NONE;
    case (step)
      3'd0: begin
        ctrl.cond      = COND_WAIT_IN;
        ctrl.accept_in = 1'b1;
      end
      3'd1: begin
        ctrl.a_sel  = A_SETPOINT;
        ctrl.b_sel  = B_SETPOINT_SCALE;
        ctrl.mul_en = 1'b1;
      end
      3'd2: begin
        ctrl.a_sel    = A_SENSOR;
        ctrl.b_sel    = B_SENSOR_SCALE;
        ctrl.mul_en   = 1'b1;
        ctrl.load_set = 1'b1;
      end
      3'd3: begin
        ctrl.load_err = 1'b1;
      end
      3'd4: begin
        ctrl.a_sel        = A_ERROR;
        ctrl.b_sel        = B_PROP_GAIN;
        ctrl.mul_en       = 1'b1;
        ctrl.update_state = 1'b1;
      end
      3'd5: begin
        ctrl.a_sel  = A_INTEGRAL;
        ctrl.b_sel  = B_INTEG_GAIN;
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = ACC_LOAD;
      end
      3'd6: begin
        ctrl.a_sel  = A_DERIV;
        ctrl.b_sel  = B_DERIV_GAIN;
        ctrl.mul_en = 1'b1;
        ctrl.acc_op = ACC_ADD;
      end
      3'd7: begin
        ctrl.cond   = COND_WAIT_OUT;
        ctrl.finish = 1'b1;
        ctrl.last   = 1'b1;
      end
      default: begin
        ctrl.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_WAIT_IN:  hold = !status.in_valid;
      COND_WAIT_OUT: hold = !status.out_free;
      default:       hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (ctrl.last) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== design/pdc_datapath.sv =====
// Shared multiplier, accumulator and loop state of the PID controller.
module pdc_datapath #(
  parameter int ADC_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pdc_pkg::ctrl_t                     ctrl,
  input  pdc_pkg::cfg_t                      cfg,
  input  logic                               in_fire,
  input  logic [ADC_BITS-1:0]                setpoint_sample,
  input  logic [ADC_BITS-1:0]                sensor_sample,
  output logic [pdc_pkg::DUTY_W-1:0]         duty_calc,
  output logic signed [pdc_pkg::ERR_W-1:0]   err_out
);
  import pdc_pkg::*;

  localparam int PROD_W = ADC_BITS + SCALE_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int WIDE_W = (DIFF_W > ERR_W) ? DIFF_W : ERR_W;
  localparam int SUM_W  = ERR_W + 1;

  localparam logic signed [WIDE_W-1:0]  ERR_HI   = WIDE_W'(ERR_MAX);
  localparam logic signed [WIDE_W-1:0]  ERR_LO   = WIDE_W'(ERR_MIN);
  localparam logic signed [INTEG_W-1:0] INTEG_HI = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_LO = {1'b1, {(INTEG_W-1){1'b0}}};

  logic [ADC_BITS-1:0]        setpoint_q;
  logic [ADC_BITS-1:0]        sensor_q;
  logic [PROD_W-1:0]          set_q8;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    last_error;
  logic signed [INTEG_W-1:0]  integral_sum;
  logic signed [SUM_W-1:0]    deriv;
  logic signed [ACC_W-1:0]    prod;
  logic signed [ACC_W-1:0]    acc;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]    mul_full;
  logic signed [WIDE_W-1:0]   diff;
  logic signed [ERR_W-1:0]    err_next;
  logic signed [SUM_W-1:0]    pair;
  logic signed [SUM_W-1:0]    inc;
  logic signed [INTEG_W:0]    integ_wide;
  logic signed [INTEG_W-1:0]  integral_next;
  logic signed [SUM_W-1:0]    deriv_next;
  logic signed [ACC_W-1:0]    total;

  always_comb begin
    case (ctrl.a_sel)
      A_SETPOINT: mul_a = signed'(MUL_A_W'(setpoint_q));
      A_SENSOR:   mul_a = signed'(MUL_A_W'(sensor_q));
      A_ERROR:    mul_a = MUL_A_W'(err);
      A_INTEGRAL: mul_a = MUL_A_W'(integral_sum);
      A_DERIV:    mul_a = MUL_A_W'(deriv);
      default:    mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_SETPOINT_SCALE: mul_b = signed'(MUL_B_W'(cfg.setpoint_scale));
      B_SENSOR_SCALE:   mul_b = signed'(MUL_B_W'(cfg.sensor_scale));
      B_PROP_GAIN:      mul_b = signed'(MUL_B_W'(cfg.prop_gain));
      B_INTEG_GAIN:     mul_b = signed'(MUL_B_W'(cfg.integ_gain));
      B_DERIV_GAIN:     mul_b = signed'(MUL_B_W'(cfg.deriv_gain));
      default:          mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Both scaled samples are non-negative, so the error never needs more
  // than one bit beyond the product width before it is saturated.
  assign diff = signed'(WIDE_W'(set_q8)) - signed'(WIDE_W'(prod[PROD_W-1:0]));

  always_comb begin
    if (diff > ERR_HI) begin
      err_next = ERR_W'(ERR_HI);
    end else if (diff < ERR_LO) begin
      err_next = ERR_W'(ERR_LO);
    end else begin
      err_next = diff[ERR_W-1:0];
    end
  end

  // The arithmetic shift gives the floor of the quarter for negative sums.
  assign pair       = SUM_W'(err) + SUM_W'(last_error);
  assign inc        = pair >>> 2;
  assign integ_wide = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(inc);
  assign deriv_next = SUM_W'(err) - SUM_W'(last_error);

  always_comb begin
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integral_next = integ_wide[INTEG_W] ? INTEG_LO : INTEG_HI;
    end else begin
      integral_next = integ_wide[INTEG_W-1:0];
    end
  end

  assign total = acc + prod;

  always_comb begin
    if (total[ACC_W-1]) begin
      duty_calc = '0;
    end else if (total[ACC_W-2:DUTY_SHIFT] > (ACC_W-1-DUTY_SHIFT)'(DUTY_MAX)) begin
      duty_calc = DUTY_W'(DUTY_MAX);
    end else begin
      duty_calc = total[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
    end
  end

  assign err_out = last_error;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      setpoint_q <= setpoint_sample;
      sensor_q   <= sensor_sample;
    end
    if (ctrl.mul_en) begin
      prod <= mul_full;
    end
    if (ctrl.load_set) begin
      set_q8 <= prod[PROD_W-1:0];
    end
    if (ctrl.load_err) begin
      err <= err_next;
    end
    if (ctrl.update_state) begin
      deriv <= deriv_next;
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= total;
      default:  acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      integral_sum <= '0;
    end else if (ctrl.update_state) begin
      last_error   <= err;
      integral_sum <= integral_next;
    end
  end

endmodule

// ===== design/pid_duty_controller.sv =====
// PID duty controller top level: register port, handshakes and result register.
//
// Each transfer on the input channel carries a setpoint and a sensor sample;
// the block scales both, forms the error, updates the derivative and the
// saturating trapezoidal integral, and returns one result with the duty in
// percent (0..100) and the saturated error. A small microcode program runs
// every item through one shared 33x17 multiplier in eight steps: one accept
// step, two scaling products, one step that forms the saturated error, three
// gain products and a finishing step that also sums and clamps. The result is
// loaded in the finishing step; the next item can be taken in the following
// cycle, so an item is taken only once the last is done. The result sits in
// an output register, and the next item is taken while it waits; the finishing
// step holds only if the previous result has still not been taken. The user
// must write gains and scales via the register port while idle (not enforced).
module pid_duty_controller #(
  parameter int ADC_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ADC_BITS-1:0]               setpoint_sample,
  input  logic [ADC_BITS-1:0]               sensor_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pdc_pkg::DUTY_W-1:0]        duty,
  output logic signed [pdc_pkg::ERR_W-1:0]  error_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pdc_pkg::ADDR_W-1:0]        paddr,
  input  logic [pdc_pkg::DATA_W-1:0]        pwdata,
  output logic [pdc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import pdc_pkg::*;

  cfg_t                     cfg;
  ctrl_t                    ctrl;
  status_t                  status;
  logic                     in_fire;
  logic                     out_free;
  logic                     load_result;
  logic                     cfg_write;
  logic [2:0]               reg_index;
  logic [DUTY_W-1:0]        duty_calc;
  logic signed [ERR_W-1:0]  err_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= GAIN_W'(4096);
      cfg.integ_gain     <= GAIN_W'(410);
      cfg.deriv_gain     <= GAIN_W'(10240);
      cfg.setpoint_scale <= SCALE_W'(25);
      cfg.sensor_scale   <= SCALE_W'(125);
    end else if (cfg_write) begin
      case (reg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain     <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= pwdata[GAIN_W-1:0];
        REG_SETPOINT_SCALE: cfg.setpoint_scale <= pwdata[SCALE_W-1:0];
        REG_SENSOR_SCALE:   cfg.sensor_scale   <= pwdata[SCALE_W-1:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PROP_GAIN:      prdata = DATA_W'(cfg.prop_gain);
      REG_INTEG_GAIN:     prdata = DATA_W'(cfg.integ_gain);
      REG_DERIV_GAIN:     prdata = DATA_W'(cfg.deriv_gain);
      REG_SETPOINT_SCALE: prdata = DATA_W'(cfg.setpoint_scale);
      REG_SENSOR_SCALE:   prdata = DATA_W'(cfg.sensor_scale);
      default:            prdata = '0;
    endcase
  end

  assign in_stall    = !ctrl.accept_in;
  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign load_result = ctrl.finish && out_free;

  assign status.in_valid = in_valid;
  assign status.out_free = out_free;

  pdc_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  pdc_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .cfg             (cfg),
    .in_fire         (in_fire),
    .setpoint_sample (setpoint_sample),
    .sensor_sample   (sensor_sample),
    .duty_calc       (duty_calc),
    .err_out         (err_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      duty        <= duty_calc;
      error_value <= err_out;
    end
  end

`ifndef SYNTHESIS
  // Once an item is taken, the program is busy with it for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("input taken again right after a transfer");

  // A finishing step blocked by a waiting result must stay where it is.
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (ctrl.finish && !out_free) |=> ctrl.finish)
    else $error("finishing step left while the result register was full");

  // A freshly loaded result always carries a clamped duty.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (duty <= DUTY_W'(DUTY_MAX)) && out_valid)
    else $error("loaded duty outside the clamp range");
`endif

endmodule
